@@ hw/rtl/mrwt_pkg.sv @@
// Package for the Miller-Rabin witness test core.
// Holds the verdict codes, fixed field widths and the multiplier status struct.
// No dependencies.
package mrwt_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [1:0] {
        VERDICT_COMPOSITE = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_INVALID   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

@@ hw/rtl/mrwt_modmul.sv @@
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on mrwt_pkg for the status struct.
module mrwt_modmul #(
    parameter int WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [WIDTH-1:0]        i_x,
    input  logic [WIDTH-1:0]        i_y,
    input  logic [WIDTH-1:0]        i_m,
    output mrwt_pkg::t_mm_status    o_status,
    output logic [WIDTH-1:0]        o_result
);
    import mrwt_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;

    logic [WIDTH:0]   w_dbl;
    logic [WIDTH-1:0] w_acc1;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH-1:0] w_acc2;
    logic [WIDTH-1:0] w_next;

    always_comb begin
        w_dbl  = {r_acc, 1'b0};
        w_acc1 = (w_dbl >= {1'b0, r_m}) ? WIDTH'(w_dbl - {1'b0, r_m}) : w_dbl[WIDTH-1:0];
        w_sum  = {1'b0, w_acc1} + {1'b0, r_x};
        w_acc2 = (w_sum >= {1'b0, r_m}) ? WIDTH'(w_sum - {1'b0, r_m}) : w_sum[WIDTH-1:0];
        w_next = r_y[WIDTH-1] ? w_acc2 : w_acc1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= w_next;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_acc;

endmodule

@@ hw/rtl/miller_rabin_witness_test_core.sv @@
// Top level of the Miller-Rabin witness test core: one round per transaction.
// Depends on mrwt_pkg and mrwt_modmul.
//
// Channel   Dir  Contents
// s_axis    in   tdata[31:0] candidate, tdata[63:32] witness
// m_axis    out  tdata[1:0] verdict, tdata[7:2] zero
//
// A round with an odd candidate has its length set by the bit-serial modular multiplier,
// which does one bit per cycle.
// Candidates below three and even ones go from ST_IDLE through ST_FIN to the output register.
// Reset is synchronous and active low and clears all control state.
// The input is not ready while a round is in progress; a finished verdict waits
// in the output register while the next transaction is accepted.
module miller_rabin_witness_test_core #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] candidate, [63:32] witness
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] verdict, [7:2] zero
);
    import mrwt_pkg::*;

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE, ST_REDUCE, ST_SHIFT, ST_PSQ, ST_PMUL, ST_CHECK, ST_SQLOOP, ST_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_n, n_n;
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_e, n_e;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_s, n_s;
    logic             r_wait, n_wait;
    t_verdict         r_verdict, n_verdict;
    logic             r_out_valid, n_out_valid;
    t_verdict         r_out_verdict, n_out_verdict;

    logic [63:0]      w_cand64;
    logic [63:0]      w_wit64;
    logic [WIDTH-1:0] w_cand;
    logic [WIDTH-1:0] w_wit;
    logic [WIDTH-1:0] w_last;

    logic             mm_start;
    logic [WIDTH-1:0] mm_x;
    logic [WIDTH-1:0] mm_y;
    t_mm_status       mm_status;
    logic [WIDTH-1:0] mm_result;

    assign w_cand64 = {32'b0, s_axis_tdata[FIELD_W-1:0]};
    assign w_wit64  = {32'b0, s_axis_tdata[2*FIELD_W-1:FIELD_W]};
    assign w_cand   = w_cand64[WIDTH-1:0];
    assign w_wit    = w_wit64[WIDTH-1:0];
    assign w_last   = r_n - 1'b1;

    mrwt_modmul #(
        .WIDTH(WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_m      (r_n),
        .o_status (mm_status),
        .o_result (mm_result)
    );

    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_base        = r_base;
        n_acc         = r_acc;
        n_e           = r_e;
        n_cnt         = r_cnt;
        n_s           = r_s;
        n_wait        = r_wait;
        n_verdict     = r_verdict;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        mm_start      = 1'b0;
        mm_x          = r_acc;
        mm_y          = r_acc;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_n    = w_cand;
                    n_base = w_wit;
                    n_e    = w_cand - 1'b1;
                    n_s    = '0;
                    n_wait = 1'b0;
                    if (w_cand < WIDTH'(2)) begin
                        n_verdict = VERDICT_INVALID;
                        n_state   = ST_FIN;
                    end else if (w_cand == WIDTH'(2)) begin
                        n_verdict = VERDICT_PRIME;
                        n_state   = ST_FIN;
                    end else if (!w_cand[0]) begin
                        n_verdict = VERDICT_COMPOSITE;
                        n_state   = ST_FIN;
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                mm_x = WIDTH'(1);
                mm_y = r_base;
                if (!r_wait) begin
                    mm_start = 1'b1;
                    n_wait   = 1'b1;
                end else if (mm_status.done) begin
                    n_base  = mm_result;
                    n_wait  = 1'b0;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!r_e[0]) begin
                    n_e = {1'b0, r_e[WIDTH-1:1]};
                    n_s = r_s + 1'b1;
                end else begin
                    n_acc   = WIDTH'(1);
                    n_cnt   = CW'(WIDTH - 1);
                    n_state = ST_PSQ;
                end
            end
            ST_PSQ, ST_PMUL: begin
                if (r_state == ST_PMUL) begin
                    mm_x = r_base;
                end
                if (!r_wait) begin
                    mm_start = 1'b1;
                    n_wait   = 1'b1;
                end else if (mm_status.done) begin
                    n_acc  = mm_result;
                    n_wait = 1'b0;
                    if (r_state == ST_PSQ && r_e[WIDTH-1]) begin
                        n_state = ST_PMUL;
                    end else begin
                        n_e = {r_e[WIDTH-2:0], 1'b0};
                        if (r_cnt == '0) begin
                            n_state = ST_CHECK;
                        end else begin
                            n_cnt   = r_cnt - 1'b1;
                            n_state = ST_PSQ;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (r_acc == WIDTH'(1)) begin
                    n_verdict = VERDICT_PRIME;
                    n_state   = ST_FIN;
                end else begin
                    n_state = ST_SQLOOP;
                end
            end
            ST_SQLOOP: begin
                if (!r_wait) begin
                    if (r_s == '0) begin
                        n_verdict = VERDICT_COMPOSITE;
                        n_state   = ST_FIN;
                    end else if (r_acc == w_last) begin
                        n_verdict = VERDICT_PRIME;
                        n_state   = ST_FIN;
                    end else begin
                        mm_start = 1'b1;
                        n_wait   = 1'b1;
                    end
                end else if (mm_status.done) begin
                    n_acc  = mm_result;
                    n_s    = r_s - 1'b1;
                    n_wait = 1'b0;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
        r_n           <= n_n;
        r_base        <= n_base;
        r_acc         <= n_acc;
        r_e           <= n_e;
        r_cnt         <= n_cnt;
        r_s           <= n_s;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_verdict};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted transaction");

    a_mm_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_status.done |-> (mm_result < r_n))
        else $error("modular product not below the modulus");

    a_mm_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_status.busy |-> !mm_start)
        else $error("multiplier started while busy");

    a_invalid_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_verdict == VERDICT_INVALID) |-> (r_n < WIDTH'(2)))
        else $error("invalid verdict for a candidate of two or more");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("undefined verdict code on the output");

endmodule

@@ tb/mrwt_round_checker.sv @@
// Checker for the Miller-Rabin witness test core: predicts one verdict per input
// transaction and compares it with the next output transaction.
// Depends on mrwt_pkg for the verdict codes and field widths.
module mrwt_round_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,     // [31:0] candidate, [63:32] witness
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,    // [1:0] verdict, [7:2] zero
    output int          o_fail_count,
    output int          o_pending
);
    import mrwt_pkg::*;

    typedef struct {
        logic [FIELD_W-1:0] candidate;
        logic [FIELD_W-1:0] witness;
        t_verdict           verdict;
    } t_round;

    t_round rounds_due[$];
    int     rounds_taken;
    int     rounds_checked;

    assign o_pending = rounds_taken - rounds_checked;

    function automatic logic [FIELD_W-1:0] mod_product(
        input logic [FIELD_W-1:0] x,
        input logic [FIELD_W-1:0] y,
        input logic [FIELD_W-1:0] m
    );
        logic [2*FIELD_W-1:0] full;
        full = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
        return FIELD_W'(full % {{FIELD_W{1'b0}}, m});
    endfunction

    function automatic logic [FIELD_W-1:0] mod_power(
        input logic [FIELD_W-1:0] base,
        input logic [FIELD_W-1:0] exponent,
        input logic [FIELD_W-1:0] m
    );
        logic [FIELD_W-1:0] acc;
        acc = 1;
        for (int bit_idx = FIELD_W - 1; bit_idx >= 0; bit_idx--) begin
            acc = mod_product(acc, acc, m);
            if (exponent[bit_idx]) begin
                acc = mod_product(acc, base, m);
            end
        end
        return acc;
    endfunction

    function automatic t_verdict witness_verdict(
        input logic [FIELD_W-1:0] n,
        input logic [FIELD_W-1:0] a
    );
        logic [FIELD_W-1:0] odd_part;
        logic [FIELD_W-1:0] b;
        int                 twos;
        if (n < 2) begin
            return VERDICT_INVALID;
        end
        if (n == 2) begin
            return VERDICT_PRIME;
        end
        if (!n[0]) begin
            return VERDICT_COMPOSITE;
        end
        odd_part = n - 1;
        twos = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        b = mod_power(a % n, odd_part, n);
        if (b == 1) begin
            return VERDICT_PRIME;
        end
        for (int r = 0; r < twos; r++) begin
            if (b == n - 1) begin
                return VERDICT_PRIME;
            end
            b = mod_product(b, b, n);
        end
        return VERDICT_COMPOSITE;
    endfunction

    always @(posedge i_clk) begin
        t_round due;
        t_round fresh;
        if (!i_rst_n) begin
            o_fail_count   = 0;
            rounds_taken   = 0;
            rounds_checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rounds_due.size() == 0) begin
                    $display("%0t: unexpected verdict transaction, expected none, got data 0x%02h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    due = rounds_due.pop_front();
                    rounds_checked++;
                    if (i_out_data[1:0] != due.verdict) begin
                        $display("%0t: verdict mismatch for n=%0d a=%0d, expected %0d, got %0d",
                                 $time, due.candidate, due.witness, due.verdict,
                                 i_out_data[1:0]);
                        o_fail_count++;
                    end
                    if (i_out_data[7:2] != '0) begin
                        $display("%0t: padding mismatch for n=%0d a=%0d, expected 0, got 0x%02h",
                                 $time, due.candidate, due.witness, i_out_data[7:2]);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh.candidate = i_in_data[FIELD_W-1:0];
                fresh.witness   = i_in_data[2*FIELD_W-1:FIELD_W];
                fresh.verdict   = witness_verdict(fresh.candidate, fresh.witness);
                rounds_due.push_back(fresh);
                rounds_taken++;
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the Miller-Rabin witness test core testbench: clock, reset, stimulus and verdict.
// Instantiates miller_rabin_witness_test_core and mrwt_round_checker; depends on mrwt_pkg.
module tb_top;
    import mrwt_pkg::*;

    localparam int RANDOM_ROUNDS = 247;
    localparam int HOLD_CYCLES   = 12000;
    localparam int HOLD_AFTER    = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int tx_count;
    int rx_count;
    bit tx_burst;
    bit rx_burst;
    bit hold_done;

    miller_rabin_witness_test_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    mrwt_round_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("miller_rabin_witness_test_core regression: fail");
        $finish;
    end

    task automatic send_round(input logic [31:0] cand, input logic [31:0] wit);
        int gap;
        if (tx_count % 16 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
        end
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {wit, cand};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        tx_count++;
    endtask

    task automatic pick_witness(input logic [31:0] cand, output logic [31:0] wit);
        if (cand > 4 && $urandom_range(0, 9) != 0) begin
            wit = $urandom_range(cand - 2, 2);
        end else begin
            wit = $urandom;
        end
    endtask

    task automatic pick_round(output logic [31:0] cand, output logic [31:0] wit);
        int          kind;
        logic [31:0] x;
        logic [31:0] y;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            cand = $urandom_range(0, 20);
            wit  = $urandom;
        end else if (kind < 16) begin
            cand = $urandom & ~32'd1;
            wit  = $urandom;
        end else if (kind < 45) begin
            case ($urandom_range(0, 11))
                0:       cand = 32'd4294967291;
                1:       cand = 32'd4294967279;
                2:       cand = 32'd2147483647;
                3:       cand = 32'd3;
                4:       cand = 32'd5;
                5:       cand = 32'd7;
                6:       cand = 32'd65537;
                7:       cand = 32'd1000000007;
                8:       cand = 32'd998244353;
                9:       cand = 32'd7919;
                10:      cand = 32'd104729;
                default: cand = 32'd3221225473;
            endcase
            pick_witness(cand, wit);
        end else if (kind < 60) begin
            case ($urandom_range(0, 5))
                0:       cand = 32'd561;
                1:       cand = 32'd1105;
                2:       cand = 32'd1729;
                3:       cand = 32'd2047;
                4:       cand = 32'd25326001;
                default: cand = 32'd3215031751;
            endcase
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0:       wit = 32'd2;
                    1:       wit = 32'd3;
                    2:       wit = 32'd5;
                    default: wit = 32'd7;
                endcase
            end else begin
                pick_witness(cand, wit);
            end
        end else if (kind < 72) begin
            x    = $urandom_range(3, 65535) | 32'd1;
            y    = $urandom_range(3, 65535) | 32'd1;
            cand = x * y;
            pick_witness(cand, wit);
        end else begin
            cand = $urandom | 32'd1;
            pick_witness(cand, wit);
        end
    endtask

    // The receiver stalls at random, and once holds off long enough to back up the input.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        rx_count      = 0;
        hold_done     = 1'b0;
        wait (i_rst_n);
        forever begin
            if (rx_count % 16 == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (!hold_done && rx_count == HOLD_AFTER) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            rx_count++;
        end
    end

    initial begin
        logic [31:0] cand;
        logic [31:0] wit;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_count      = 0;
        tx_burst      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Invalid, two, even and witness-reduction cases, then deep odd cases.
        send_round(32'd0, 32'd5);
        send_round(32'd1, 32'hFFFF_FFFF);
        send_round(32'd2, 32'd0);
        send_round(32'd2, 32'hFFFF_FFFF);
        send_round(32'd4, 32'd3);
        send_round(32'hFFFF_FFFE, 32'h0001_2345);
        send_round(32'd3, 32'd2);
        send_round(32'd3, 32'd0);
        send_round(32'd3, 32'd3);
        send_round(32'd4294967291, 32'd2);
        send_round(32'd4294967291, 32'd1);
        send_round(32'd4294967291, 32'd4294967290);
        send_round(32'd4294967291, 32'hFFFF_FFFF);
        send_round(32'hFFFF_FFFF, 32'd2);
        send_round(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_round(32'd2047, 32'd2);
        send_round(32'd561, 32'd2);
        send_round(32'd3215031751, 32'd7);
        send_round(32'd65537, 32'd3);
        send_round(32'd2147483649, 32'd2);
        send_round(32'd2147483649, 32'd5);
        send_round(32'd9, 32'h8000_0000);
        send_round(32'd1105, 32'd0);

        for (int i = 0; i < RANDOM_ROUNDS; i++) begin
            pick_round(cand, wit);
            send_round(cand, wit);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("miller_rabin_witness_test_core regression: pass");
        end else begin
            $display("miller_rabin_witness_test_core regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mrwt_pkg.sv
hw/rtl/mrwt_modmul.sv
hw/rtl/miller_rabin_witness_test_core.sv
tb/mrwt_round_checker.sv
tb/tb_top.sv
